/* hw/rtl/undirected_adjacency_table_assert.svh */
// assertion macros for the checker file
`ifndef UNDIRECTED_ADJACENCY_TABLE_ASSERT_SVH
`define UNDIRECTED_ADJACENCY_TABLE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define UAT_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("uat assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define UAT_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("uat assertion failed");

`endif

/* hw/rtl/uat_pkg.sv */
// ----------------------------------------------------------------------------
// uat_pkg
// Shared types and constants of the undirected adjacency table.
// ----------------------------------------------------------------------------
package uat_pkg;

    localparam int MAX_VERTICES_DEF = 32;

    // operation codes
    localparam logic [2:0] OP_ADD_VERTEX = 3'd0;
    localparam logic [2:0] OP_DEL_VERTEX = 3'd1;
    localparam logic [2:0] OP_ADD_EDGE   = 3'd2;
    localparam logic [2:0] OP_DEL_EDGE   = 3'd3;
    localparam logic [2:0] OP_CHK_EDGE   = 3'd4;
    localparam logic [2:0] OP_QUERY      = 3'd5;

    // statistic widths, wide enough for a table of 64 vertices
    localparam int SUM_W = 13;
    localparam int CNT_W = 7;

    // operation broadcast to every cell
    typedef struct packed {
        logic       active;
        logic [2:0] op;
        logic [4:0] a;
        logic [4:0] b;
        logic       hit_ab;
    } uat_cmd_t;

    // running statistics passed down the chain
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] cnt;
        logic [CNT_W-1:0] maxd;
        logic [CNT_W-1:0] mind;
    } uat_tok_t;

endpackage

/* hw/rtl/uat_in_if.sv */
// ----------------------------------------------------------------------------
// uat_in_if
// Operation channel: valid/ready with one operation per transaction.
// ----------------------------------------------------------------------------
interface uat_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [4:0] vertex_a;
    logic [4:0] vertex_b;

    modport source (output valid, output op, output vertex_a, output vertex_b, input ready);
    modport sink (input valid, input op, input vertex_a, input vertex_b, output ready);
endinterface

/* hw/rtl/uat_out_if.sv */
// ----------------------------------------------------------------------------
// uat_out_if
// Result channel: valid/ready with one result per transaction.
// ----------------------------------------------------------------------------
interface uat_out_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic [31:0] neighbor_mask;
    logic        vertex_known;
    logic [9:0]  edge_count;
    logic [5:0]  max_degree;
    logic [5:0]  min_degree;

    modport source (output valid, output ok, output neighbor_mask, output vertex_known,
                    output edge_count, output max_degree, output min_degree, input ready);
    modport sink (input valid, input ok, input neighbor_mask, input vertex_known,
                  input edge_count, input max_degree, input min_degree, output ready);
endinterface

/* hw/rtl/uat_cell.sv */
// ----------------------------------------------------------------------------
// uat_cell
// One vertex: present bit, adjacency row, degree, and one statistics stage.
// ----------------------------------------------------------------------------
module uat_cell
    import uat_pkg::*;
#(
    parameter int N     = MAX_VERTICES_DEF,
    parameter int INDEX = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  uat_cmd_t       cmd,
    input  logic [N-1:0]   row_a,
    output logic [N-1:0]   row,
    output logic           present,
    input  logic           go_in,
    input  uat_tok_t       tok_in,
    output logic           go_out,
    output uat_tok_t       tok_out
);

    localparam logic [6:0] ID = 7'(INDEX);

    logic [N-1:0]   row_reg, row_next;
    logic           pres_reg, pres_next;
    logic           go_reg;
    uat_tok_t       tok_reg, tok_next;
    logic           is_a, is_b;
    logic [N-1:0]   amask, bmask;
    logic [CNT_W-1:0] deg;

    assign is_a  = ({2'b00, cmd.a} == ID);
    assign is_b  = ({2'b00, cmd.b} == ID);
    assign amask = N'(1) << cmd.a;
    assign bmask = N'(1) << cmd.b;

    // table update for the broadcast operation
    always_comb
    begin
        row_next  = row_reg;
        pres_next = pres_reg;
        if (cmd.active)
        begin
            unique case (cmd.op)
                OP_ADD_VERTEX:
                begin
                    if (is_a)
                    begin
                        pres_next = 1'b1;
                        row_next  = '0;
                    end
                end
                OP_DEL_VERTEX:
                begin
                    if (row_a[INDEX])
                    begin
                        pres_next = 1'b1;
                        row_next  = row_next & ~amask;
                    end
                    if (is_a)
                    begin
                        pres_next = 1'b0;
                        row_next  = '0;
                    end
                end
                OP_ADD_EDGE:
                begin
                    if (is_a)
                    begin
                        pres_next = 1'b1;
                        row_next  = row_next | bmask;
                    end
                    if (is_b)
                    begin
                        pres_next = 1'b1;
                        row_next  = row_next | amask;
                    end
                end
                OP_DEL_EDGE:
                begin
                    if (is_a)
                        pres_next = 1'b1;
                    if (cmd.hit_ab)
                    begin
                        if (is_a)
                            row_next = row_next & ~bmask;
                        if (is_b)
                        begin
                            pres_next = 1'b1;
                            row_next  = row_next & ~amask;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // statistics stage
    assign deg = CNT_W'($countones(row_reg));

    always_comb
    begin
        tok_next = tok_in;
        if (pres_reg)
        begin
            tok_next.sum = tok_in.sum + SUM_W'(deg);
            tok_next.cnt = tok_in.cnt + CNT_W'(1);
            if (deg > tok_in.maxd)
                tok_next.maxd = deg;
            if (deg < tok_in.mind)
                tok_next.mind = deg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            pres_reg <= 1'b0;
            go_reg   <= 1'b0;
        end
        else
        begin
            row_reg  <= row_next;
            pres_reg <= pres_next;
            go_reg   <= go_in;
        end
    end

    // token payload
    always_ff @(posedge clk)
    begin
        if (go_in)
            tok_reg <= tok_next;
    end

    assign row     = row_reg;
    assign present = pres_reg;
    assign go_out  = go_reg;
    assign tok_out = tok_reg;

endmodule

/* hw/rtl/undirected_adjacency_table.sv */
// a new operation is taken only in the idle state, once the previous result is loaded;
//   the statistics token walks the cell chain one cell per cycle
// a result still waiting in the output register holds the next operation in its last step
// reset (rst_n, async, active low) empties the table at once, no clearing pass
// ----------------------------------------------------------------------------
// undirected_adjacency_table
// Adjacency bit table kept as a chain of vertex cells with degree statistics.
// ----------------------------------------------------------------------------
module undirected_adjacency_table
    import uat_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    uat_in_if.sink   in_ch,
    uat_out_if.source out_ch
);

    localparam int N  = MAX_VERTICES;
    localparam int IW = (N > 2) ? $clog2(N) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_APPLY = 3'd2;
    localparam logic [2:0] S_POST  = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]   state_reg, state_next;
    logic [2:0]   op_reg;
    logic [4:0]   a_reg, b_reg;
    logic         valid_reg, edge_reg;
    logic [N-1:0] rowa_reg;
    logic         hit_ab_reg, hit_ba_reg, pres_a_reg;
    logic         ok_reg, ok_next;
    logic         known_reg;
    logic [31:0]  mask_reg;
    uat_tok_t     stat_reg;

    logic         out_valid_reg;
    logic         out_ok_reg, out_known_reg;
    logic [31:0]  out_mask_reg;
    logic [9:0]   out_edges_reg;
    logic [5:0]   out_max_reg, out_min_reg;

    logic [N-1:0] row_w [N];
    logic         pres_w [N];
    logic         go_w [N+1];
    uat_tok_t     tok_w [N+1];
    uat_cmd_t     cmd;
    logic [IW-1:0] a_idx, b_idx;
    logic         in_fire, in_edge, a_ok, b_ok, out_load;
    logic [CNT_W-1:0] min_cap;

    assign in_fire = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_edge = (in_ch.op == OP_ADD_EDGE) || (in_ch.op == OP_DEL_EDGE)
                     || (in_ch.op == OP_CHK_EDGE);
    assign a_ok = ({2'b00, in_ch.vertex_a} < 7'(N));
    assign b_ok = ({2'b00, in_ch.vertex_b} < 7'(N));
    assign a_idx = IW'(a_reg);
    assign b_idx = IW'(b_reg);
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ch.ready);

    // minimum degree never exceeds the vertex count plus one
    assign min_cap = stat_reg.cnt + CNT_W'(1);

    // broadcast command
    always_comb
    begin
        cmd.active = (state_reg == S_APPLY) && valid_reg;
        cmd.op     = op_reg;
        cmd.a      = a_reg;
        cmd.b      = b_reg;
        cmd.hit_ab = hit_ab_reg;
    end

    // cell chain
    assign go_w[0]       = (state_reg == S_POST);
    assign tok_w[0].sum  = '0;
    assign tok_w[0].cnt  = '0;
    assign tok_w[0].maxd = '0;
    assign tok_w[0].mind = CNT_W'(N);

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        uat_cell #(.N(N), .INDEX(i)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd),
            .row_a   (rowa_reg),
            .row     (row_w[i]),
            .present (pres_w[i]),
            .go_in   (go_w[i]),
            .tok_in  (tok_w[i]),
            .go_out  (go_w[i+1]),
            .tok_out (tok_w[i+1])
        );
    end

    // outcome of the operation
    always_comb
    begin
        ok_next = !edge_reg;
        if (valid_reg)
        begin
            case (op_reg)
                OP_ADD_EDGE: ok_next = !hit_ab_reg && !hit_ba_reg && (a_reg != b_reg);
                OP_DEL_EDGE: ok_next = hit_ab_reg;
                OP_CHK_EDGE: ok_next = pres_a_reg && hit_ab_reg;
                default:     ok_next = 1'b1;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_fire) state_next = S_LOAD;
            S_LOAD:  state_next = S_APPLY;
            S_APPLY: state_next = S_POST;
            S_POST:  state_next = S_SCAN;
            S_SCAN:  if (go_w[N]) state_next = S_DONE;
            S_DONE:  if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // operation payload and result capture
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg    <= in_ch.op;
            a_reg     <= in_ch.vertex_a;
            b_reg     <= in_ch.vertex_b;
            edge_reg  <= in_edge;
            valid_reg <= a_ok && (!in_edge || b_ok);
        end
        if (state_reg == S_LOAD)
        begin
            rowa_reg   <= row_w[a_idx];
            hit_ab_reg <= row_w[a_idx][b_idx];
            hit_ba_reg <= row_w[b_idx][a_idx];
            pres_a_reg <= pres_w[a_idx];
        end
        if (state_reg == S_APPLY)
            ok_reg <= ok_next;
        if (state_reg == S_POST)
        begin
            known_reg <= valid_reg && pres_w[a_idx];
            mask_reg  <= (valid_reg && pres_w[a_idx]) ? 32'(row_w[a_idx]) : 32'd0;
        end
        if (go_w[N])
            stat_reg <= tok_w[N];
        if (out_load)
        begin
            out_ok_reg    <= ok_reg;
            out_known_reg <= known_reg;
            out_mask_reg  <= mask_reg;
            out_edges_reg <= 10'(stat_reg.sum >> 1);
            out_max_reg   <= 6'(stat_reg.maxd);
            out_min_reg   <= (min_cap < stat_reg.mind) ? 6'(min_cap) : 6'(stat_reg.mind);
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.ok            = out_ok_reg;
    assign out_ch.neighbor_mask = out_mask_reg;
    assign out_ch.vertex_known  = out_known_reg;
    assign out_ch.edge_count    = out_edges_reg;
    assign out_ch.max_degree    = out_max_reg;
    assign out_ch.min_degree    = out_min_reg;

endmodule

/* hw/rtl/uat_checker.sv */
// ----------------------------------------------------------------------------
// uat_checker
// Port-level assertions on the adjacency table, bound to the top level.
// ----------------------------------------------------------------------------
`include "undirected_adjacency_table_assert.svh"

module uat_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] neighbor_mask,
    input logic        vertex_known,
    input logic [5:0]  max_degree,
    input logic [5:0]  min_degree
);

    // a stalled result holds its row
    `UAT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(neighbor_mask))

    // an absent vertex reports an empty row
    `UAT_ASSERT_NOW(a_absent_row, out_valid && !vertex_known, neighbor_mask == 32'd0)

    // with a vertex present the minimum degree cannot pass the maximum
    `UAT_ASSERT_NOW(a_min_max, out_valid && vertex_known,
                    (min_degree <= max_degree) || (max_degree == 6'd0))

endmodule

bind undirected_adjacency_table uat_checker u_uat_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .neighbor_mask (out_ch.neighbor_mask),
    .vertex_known  (out_ch.vertex_known),
    .max_degree    (out_ch.max_degree),
    .min_degree    (out_ch.min_degree)
);

/* tb/tb_undirected_adjacency_table.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_undirected_adjacency_table
// Drives graph operations through the operation channel, predicts each
// result with a local table model and compares every result field.
// ----------------------------------------------------------------------------
module tb_undirected_adjacency_table;
    import uat_pkg::*;

    localparam int NV = 32;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic        ok;
        logic [31:0] neighbor_mask;
        logic        vertex_known;
        logic [9:0]  edge_count;
        logic [5:0]  max_degree;
        logic [5:0]  min_degree;
    } graph_result_t;

    logic clk;
    logic rst_n;
    uat_in_if  in_ch ();
    uat_out_if out_ch ();

    undirected_adjacency_table dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // predictor state
    logic [31:0]   model_present;
    logic [31:0]   model_rows [NV];
    graph_result_t expected_results [$];
    int            error_count;
    int            cycle_count;
    int            stall_mode;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_undirected_adjacency_table failed");
            $finish;
        end
    end

    // apply one operation to the model and return the expected result
    function automatic graph_result_t apply_graph_op(logic [2:0] op, logic [4:0] a,
                                                      logic [4:0] b);
        graph_result_t r;
        logic n1;
        logic n2;
        int cnt;
        int sum;
        int deg;
        int maxd;
        int mind;
        r = '0;
        r.ok = !(op == OP_ADD_EDGE || op == OP_DEL_EDGE || op == OP_CHK_EDGE);
        case (op)
            OP_ADD_VERTEX:
            begin
                model_present[a] = 1'b1;
                model_rows[a] = '0;
            end
            OP_DEL_VERTEX:
            begin
                for (int i = 0; i < NV; i++)
                    if (model_rows[a][i])
                    begin
                        model_present[i] = 1'b1;
                        model_rows[i][a] = 1'b0;
                    end
                model_rows[a] = '0;
                model_present[a] = 1'b0;
            end
            OP_ADD_EDGE:
            begin
                model_present[a] = 1'b1;
                n1 = !model_rows[a][b];
                model_rows[a][b] = 1'b1;
                model_present[b] = 1'b1;
                n2 = !model_rows[b][a];
                model_rows[b][a] = 1'b1;
                r.ok = n1 && n2;
            end
            OP_DEL_EDGE:
            begin
                model_present[a] = 1'b1;
                if (model_rows[a][b])
                begin
                    model_rows[a][b] = 1'b0;
                    model_present[b] = 1'b1;
                    model_rows[b][a] = 1'b0;
                    r.ok = 1'b1;
                end
            end
            OP_CHK_EDGE:
                r.ok = model_present[a] && model_rows[a][b];
            default:
                ;
        endcase
        r.vertex_known = model_present[a];
        r.neighbor_mask = model_present[a] ? model_rows[a] : '0;
        cnt = 0;
        sum = 0;
        maxd = 0;
        for (int i = 0; i < NV; i++)
            if (model_present[i])
                cnt++;
        mind = cnt + 1;
        for (int i = 0; i < NV; i++)
            if (model_present[i])
            begin
                deg = $countones(model_rows[i]);
                sum += deg;
                if (deg > maxd) maxd = deg;
                if (deg < mind) mind = deg;
            end
        r.edge_count = 10'(sum / 2);
        r.max_degree = 6'(maxd);
        r.min_degree = 6'(mind);
        return r;
    endfunction

    // send one operation, predicted at acceptance
    task automatic send_graph_op(logic [2:0] op, logic [4:0] a, logic [4:0] b);
        in_ch.valid <= 1'b1;
        in_ch.op <= op;
        in_ch.vertex_a <= a;
        in_ch.vertex_b <= b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        expected_results.insert(expected_results.size(), apply_graph_op(op, a, b));
        @(negedge clk);
    endtask

    task automatic idle_cycles(int n);
        in_ch.valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // receiver stall pattern
    always @(negedge clk)
    begin
        case (stall_mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= ($urandom_range(0, 3) != 0);
            default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // result checker
    always @(posedge clk)
    begin
        graph_result_t got;
        graph_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = {out_ch.ok, out_ch.neighbor_mask, out_ch.vertex_known,
                   out_ch.edge_count, out_ch.max_degree, out_ch.min_degree};
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.ok !== want.ok)
                    $display("%0t: ok exp %h got %h", $time, want.ok, got.ok);
                if (got.neighbor_mask !== want.neighbor_mask)
                    $display("%0t: neighbor_mask exp %h got %h", $time,
                             want.neighbor_mask, got.neighbor_mask);
                if (got.vertex_known !== want.vertex_known)
                    $display("%0t: vertex_known exp %h got %h", $time,
                             want.vertex_known, got.vertex_known);
                if (got.edge_count !== want.edge_count)
                    $display("%0t: edge_count exp %0d got %0d", $time,
                             want.edge_count, got.edge_count);
                if (got.max_degree !== want.max_degree)
                    $display("%0t: max_degree exp %0d got %0d", $time,
                             want.max_degree, got.max_degree);
                if (got.min_degree !== want.min_degree)
                    $display("%0t: min_degree exp %0d got %0d", $time,
                             want.min_degree, got.min_degree);
                if (got !== want)
                    error_count++;
            end
        end
    end

    // every operation and the extremes of the identifiers
    task automatic test_directed_ops();
        send_graph_op(OP_QUERY, 5'd0, 5'd0);
        send_graph_op(OP_CHK_EDGE, 5'd31, 5'd0);
        send_graph_op(OP_ADD_VERTEX, 5'd0, 5'd31);
        send_graph_op(OP_ADD_EDGE, 5'd0, 5'd31);
        send_graph_op(OP_ADD_EDGE, 5'd31, 5'd0);
        send_graph_op(OP_ADD_EDGE, 5'd7, 5'd7);
        send_graph_op(OP_CHK_EDGE, 5'd0, 5'd31);
        send_graph_op(OP_CHK_EDGE, 5'd31, 5'd5);
        send_graph_op(OP_ADD_EDGE, 5'd21, 5'd10);
        // re-adding a vertex clears only its own row
        send_graph_op(OP_ADD_VERTEX, 5'd21, 5'd0);
        send_graph_op(OP_QUERY, 5'd10, 5'd0);
        send_graph_op(OP_DEL_EDGE, 5'd10, 5'd21);
        send_graph_op(OP_DEL_EDGE, 5'd10, 5'd21);
        send_graph_op(OP_DEL_EDGE, 5'd12, 5'd3);
        send_graph_op(OP_DEL_VERTEX, 5'd31, 5'd0);
        send_graph_op(OP_DEL_VERTEX, 5'd31, 5'd0);
        // unused op codes act as queries
        send_graph_op(3'd6, 5'd0, 5'd31);
        send_graph_op(3'd7, 5'd31, 5'd31);
        send_graph_op(OP_DEL_EDGE, 5'd7, 5'd7);
        send_graph_op(OP_QUERY, 5'd7, 5'd0);
        idle_cycles(1);
    endtask

    // random traffic in bursts, biased toward edge operations, on vertices 0 to span
    task automatic test_random_ops(int count, int span);
        int burst;
        logic [2:0] op;
        logic [4:0] a;
        logic [4:0] b;
        for (int n = 0; n < count; )
        begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst && n < count; k++, n++)
            begin
                case ($urandom_range(0, 15))
                    0, 1:        op = OP_ADD_VERTEX;
                    2:           op = OP_DEL_VERTEX;
                    3, 4, 5, 6:  op = OP_ADD_EDGE;
                    7, 8:        op = OP_DEL_EDGE;
                    9, 10, 11:   op = OP_CHK_EDGE;
                    12, 13:      op = OP_QUERY;
                    default:     op = 3'($urandom_range(0, 7));
                endcase
                a = 5'($urandom_range(0, span));
                b = 5'($urandom_range(0, span));
                send_graph_op(op, a, b);
            end
            if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 40));
        end
        idle_cycles(1);
    endtask

    // drain all expected results
    task automatic wait_drain();
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (NV + 10) @(negedge clk);
    endtask

    initial
    begin
        error_count = 0;
        cycle_count = 0;
        stall_mode = 0;
        model_present = '0;
        for (int i = 0; i < NV; i++)
            model_rows[i] = '0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.op = '0;
        in_ch.vertex_a = '0;
        in_ch.vertex_b = '0;
        out_ch.ready = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        test_directed_ops();
        stall_mode = 1;
        test_random_ops(200, 7);
        stall_mode = 2;
        test_random_ops(200, 31);
        stall_mode = 0;
        test_random_ops(150, 12);
        wait_drain();
        if (error_count == 0)
            $display("tb_undirected_adjacency_table passed");
        else
            $display("tb_undirected_adjacency_table failed");
        $finish;
    end
endmodule
